// ----- rtl/block_cache_tag_lru_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the block cache tag store
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BLOCK_CACHE_TAG_LRU_CORE_MACROS_SVH
`define BLOCK_CACHE_TAG_LRU_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BCTL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bctl check failed");

// next-cycle implication
`define BCTL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bctl check failed");

`else

`define BCTL_ASSERT_IMP(label, ante, cons)
`define BCTL_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- rtl/bctl_pkg.sv -----
// ---------------------------------------------------------------------------
// bctl_pkg
// Shared types and constants of the block cache tag store with LRU order.
// ---------------------------------------------------------------------------
package bctl_pkg;

    localparam int SLOTS_DEFAULT     = 64;
    localparam int KEY_WIDTH_DEFAULT = 48;

    localparam int CAP_W       = 7;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = 1'b1;

    // operation kinds on the input channel
    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_LOOK,
        S_W1,
        S_W2,
        S_W3,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_OFF,      // cache disabled
        OP_HIT,      // search hit
        OP_MISS,     // search miss
        OP_HEAD,     // insert of key already most recent
        OP_PROMOTE,  // insert of present key, moved to head
        OP_ALLOC,    // insert into a fresh slot
        OP_EVICT     // insert reusing the least recent slot
    } op_t;

    typedef struct packed {
        logic   capture;  // input item taken this cycle
        logic   load;     // result register loads this cycle
        state_t step;
        op_t    op;
    } cmd_t;

    typedef struct packed {
        logic enable;
        logic kind;
        logic found;
        logic is_head;
        logic room;
    } status_t;

endpackage

// ----- rtl/block_cache_tag_lru_core.sv -----
// ---------------------------------------------------------------------------
// block_cache_tag_lru_core
// Fully associative sector tag store with least-recently-used replacement.
// ---------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | kind, sector
//  out      | out_valid / out_ready| hit, slot, allocated, evicted, evicted_sector,
//           |                      | hit_count, miss_count, move_count
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  Searches, disabled items and inserts of the current head step through
//  capture, registered tag match, lookup and result load. Inserts that touch
//  the recency list add three writes through the single write port of each
//  link memory before the result load. One item is in flight at a time; a
//  result waiting on out_ready holds the sequencer in its final step. Reset
//  needs no clearing pass: the fill count masks slots never written.
//
module block_cache_tag_lru_core #(
    parameter int SLOTS     = bctl_pkg::SLOTS_DEFAULT,
    parameter int KEY_WIDTH = bctl_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bctl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bctl_pkg::CAP_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [KEY_WIDTH-1:0]             sector,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic [$clog2(SLOTS)-1:0]         slot,
    output logic                             allocated,
    output logic                             evicted,
    output logic [KEY_WIDTH-1:0]             evicted_sector,
    output logic [bctl_pkg::COUNT_W-1:0]     hit_count,
    output logic [bctl_pkg::COUNT_W-1:0]     miss_count,
    output logic [bctl_pkg::COUNT_W-1:0]     move_count
);

    bctl_pkg::cmd_t    cmd;
    bctl_pkg::status_t status;

    bctl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bctl_dpath #(
        .SLOTS     (SLOTS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .sector         (sector),
        .cmd            (cmd),
        .status         (status),
        .hit            (hit),
        .slot           (slot),
        .allocated      (allocated),
        .evicted        (evicted),
        .evicted_sector (evicted_sector),
        .hit_count      (hit_count),
        .miss_count     (miss_count),
        .move_count     (move_count)
    );

endmodule

// ----- rtl/bctl_ctrl.sv -----
// ---------------------------------------------------------------------------
// bctl_ctrl
// Sequencer: walks each item through match, lookup and list update steps.
// ---------------------------------------------------------------------------
`include "block_cache_tag_lru_core_macros.svh"

module bctl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bctl_pkg::status_t status,
    output bctl_pkg::cmd_t    cmd
);

    bctl_pkg::state_t state_reg;
    bctl_pkg::state_t state_next;
    bctl_pkg::op_t    op_reg;
    bctl_pkg::op_t    op_dec;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             res_room;

    assign res_room = !out_valid_reg || out_ready;

    always_comb
    begin
        if (!status.enable)
        begin
            op_dec = bctl_pkg::OP_OFF;
        end
        else if (status.kind == bctl_pkg::KIND_SEARCH)
        begin
            op_dec = status.found ? bctl_pkg::OP_HIT : bctl_pkg::OP_MISS;
        end
        else if (status.found)
        begin
            op_dec = status.is_head ? bctl_pkg::OP_HEAD : bctl_pkg::OP_PROMOTE;
        end
        else
        begin
            op_dec = status.room ? bctl_pkg::OP_ALLOC : bctl_pkg::OP_EVICT;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bctl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bctl_pkg::S_MATCH;
                end
            end
            bctl_pkg::S_MATCH:
            begin
                state_next = bctl_pkg::S_LOOK;
            end
            bctl_pkg::S_LOOK:
            begin
                if (op_dec == bctl_pkg::OP_PROMOTE || op_dec == bctl_pkg::OP_ALLOC ||
                    op_dec == bctl_pkg::OP_EVICT)
                begin
                    state_next = bctl_pkg::S_W1;
                end
                else
                begin
                    state_next = bctl_pkg::S_FINISH;
                end
            end
            bctl_pkg::S_W1:
            begin
                state_next = bctl_pkg::S_W2;
            end
            bctl_pkg::S_W2:
            begin
                state_next = bctl_pkg::S_W3;
            end
            bctl_pkg::S_W3:
            begin
                state_next = bctl_pkg::S_FINISH;
            end
            bctl_pkg::S_FINISH:
            begin
                if (res_room)
                begin
                    state_next = bctl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bctl_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = (state_reg == bctl_pkg::S_IDLE);
        cmd.capture = in_valid && (state_reg == bctl_pkg::S_IDLE);
        cmd.load    = (state_reg == bctl_pkg::S_FINISH) && res_room;
        cmd.step    = state_reg;
        cmd.op      = (state_reg == bctl_pkg::S_LOOK) ? op_dec : op_reg;
        out_valid   = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bctl_pkg::S_IDLE;
            op_reg        <= bctl_pkg::OP_OFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == bctl_pkg::S_LOOK)
            begin
                op_reg <= op_dec;
            end
        end
    end

    // list update steps only run for ops that touch the list
    `BCTL_ASSERT_IMP(a_w1_op, state_reg == bctl_pkg::S_W1, op_reg == bctl_pkg::OP_PROMOTE || op_reg == bctl_pkg::OP_ALLOC || op_reg == bctl_pkg::OP_EVICT)
    `BCTL_ASSERT_NXT(a_load_valid, cmd.load, out_valid_reg)
    `BCTL_ASSERT_NXT(a_capture_match, cmd.capture, state_reg == bctl_pkg::S_MATCH)

endmodule

// ----- rtl/bctl_dpath.sv -----
// ---------------------------------------------------------------------------
// bctl_dpath
// Tag match array, recency link memories, configuration and result registers.
// ---------------------------------------------------------------------------
`include "block_cache_tag_lru_core_macros.svh"

module bctl_dpath #(
    parameter int SLOTS     = bctl_pkg::SLOTS_DEFAULT,
    parameter int KEY_WIDTH = bctl_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bctl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bctl_pkg::CAP_W-1:0]          cfg_data,
    input  logic                                kind,
    input  logic [KEY_WIDTH-1:0]                sector,
    input  bctl_pkg::cmd_t                      cmd,
    output bctl_pkg::status_t                   status,
    output logic                                hit,
    output logic [$clog2(SLOTS)-1:0]            slot,
    output logic                                allocated,
    output logic                                evicted,
    output logic [KEY_WIDTH-1:0]                evicted_sector,
    output logic [bctl_pkg::COUNT_W-1:0]        hit_count,
    output logic [bctl_pkg::COUNT_W-1:0]        miss_count,
    output logic [bctl_pkg::COUNT_W-1:0]        move_count
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CNT_W > bctl_pkg::CAP_W) ? CNT_W : bctl_pkg::CAP_W;
    localparam int LINK_W = SLOT_W + 1;  // {has, pointer}
    localparam int CW     = bctl_pkg::COUNT_W;

    // configuration
    logic                       enable_reg;
    logic [bctl_pkg::CAP_W-1:0] capacity_reg;

    // item
    logic                 kind_reg;
    logic [KEY_WIDTH-1:0] key_reg;

    // tag store
    logic [KEY_WIDTH-1:0] cam_reg [SLOTS];
    logic [KEY_WIDTH-1:0] key_mem [SLOTS];
    logic [LINK_W-1:0]    newer_mem [SLOTS];
    logic [LINK_W-1:0]    older_mem [SLOTS];
    logic [KEY_WIDTH-1:0] rd_key_reg;
    logic [LINK_W-1:0]    rd_newer_reg;
    logic [LINK_W-1:0]    rd_older_reg;

    logic [SLOTS-1:0] match_reg;
    logic [SLOTS-1:0] match_next;
    logic [SLOT_W-1:0] where;
    logic              found;

    // list and fill state
    logic [SLOT_W-1:0] mr_reg;
    logic [SLOT_W-1:0] least_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [SLOT_W-1:0] x_reg;
    logic [SLOT_W-1:0] x_next;
    logic              nonempty_reg;
    logic              room;
    logic [CMP_W-1:0]  cap_eff;

    // counters
    logic [CW-1:0] hits_reg;
    logic [CW-1:0] misses_reg;
    logic [CW-1:0] moves_reg;
    logic [CW-1:0] hits_next;
    logic [CW-1:0] misses_next;
    logic [CW-1:0] moves_next;

    // result register
    logic                 hit_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 alloc_reg;
    logic                 evict_reg;
    logic [KEY_WIDTH-1:0] ev_key_reg;
    logic [CW-1:0]        hit_count_reg;
    logic [CW-1:0]        miss_count_reg;
    logic [CW-1:0]        move_count_reg;

    // write controls
    logic              nw_we;
    logic [SLOT_W-1:0] nw_addr;
    logic [LINK_W-1:0] nw_data;
    logic              ol_we;
    logic [SLOT_W-1:0] ol_addr;
    logic [LINK_W-1:0] ol_data;
    logic              least_we;
    logic [SLOT_W-1:0] least_data;
    logic              mr_we;
    logic              key_we;
    logic              used_inc;
    logic              ne;

    logic [SLOT_W-1:0] n_ptr;
    logic              n_has;
    logic [SLOT_W-1:0] o_ptr;
    logic              o_has;

    assign n_ptr = rd_newer_reg[SLOT_W-1:0];
    assign n_has = rd_newer_reg[SLOT_W];
    assign o_ptr = rd_older_reg[SLOT_W-1:0];
    assign o_has = rd_older_reg[SLOT_W];

    // parallel tag compare, limited to slots in service
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match_next[i] = (CNT_W'(i) < used_reg) && (cam_reg[i] == key_reg);
        end
    end

    // keys are unique, so the match vector is one-hot or empty
    always_comb
    begin
        where = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (match_reg[i])
            begin
                where = where | SLOT_W'(i);
            end
        end
    end

    assign found = |match_reg;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(SLOTS))
        begin
            cap_eff = CMP_W'(SLOTS);
        end
        else
        begin
            cap_eff = CMP_W'(capacity_reg);
        end
    end

    assign room = CMP_W'(used_reg) < cap_eff;

    always_comb
    begin
        if (found)
        begin
            x_next = where;
        end
        else if (room)
        begin
            x_next = used_reg[SLOT_W-1:0];
        end
        else
        begin
            x_next = least_reg;
        end
    end

    assign status.enable  = enable_reg;
    assign status.kind    = kind_reg;
    assign status.found   = found;
    assign status.is_head = (where == mr_reg);
    assign status.room    = room;

    // link update steps
    always_comb
    begin
        nw_we      = 1'b0;
        nw_addr    = x_reg;
        nw_data    = '0;
        ol_we      = 1'b0;
        ol_addr    = x_reg;
        ol_data    = '0;
        least_we   = 1'b0;
        least_data = x_reg;
        mr_we      = 1'b0;
        key_we     = 1'b0;
        used_inc   = 1'b0;

        unique case (cmd.op)
            bctl_pkg::OP_PROMOTE: ne = 1'b1;
            bctl_pkg::OP_EVICT:   ne = n_has;
            default:              ne = nonempty_reg;
        endcase

        unique case (cmd.step)
            bctl_pkg::S_W1:
            begin
                unique case (cmd.op)
                    bctl_pkg::OP_PROMOTE:
                    begin
                        // unlink x: its newer neighbor takes over x's older link
                        ol_we   = 1'b1;
                        ol_addr = n_ptr;
                        ol_data = {o_has, o_ptr};
                        if (o_has)
                        begin
                            nw_we   = 1'b1;
                            nw_addr = o_ptr;
                            nw_data = {1'b1, n_ptr};
                        end
                        else
                        begin
                            least_we   = 1'b1;
                            least_data = n_ptr;
                        end
                    end
                    bctl_pkg::OP_EVICT:
                    begin
                        key_we = 1'b1;
                        if (n_has)
                        begin
                            ol_we      = 1'b1;
                            ol_addr    = n_ptr;
                            ol_data    = '0;
                            least_we   = 1'b1;
                            least_data = n_ptr;
                        end
                    end
                    bctl_pkg::OP_ALLOC:
                    begin
                        key_we   = 1'b1;
                        used_inc = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            bctl_pkg::S_W2:
            begin
                nw_we   = 1'b1;
                nw_addr = x_reg;
                nw_data = '0;
                ol_we   = 1'b1;
                ol_addr = x_reg;
                ol_data = ne ? {1'b1, mr_reg} : LINK_W'(0);
                if (!ne)
                begin
                    least_we   = 1'b1;
                    least_data = x_reg;
                end
            end
            bctl_pkg::S_W3:
            begin
                mr_we = 1'b1;
                if (ne)
                begin
                    nw_we   = 1'b1;
                    nw_addr = mr_reg;
                    nw_data = {1'b1, x_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        hits_next   = hits_reg + CW'(cmd.op == bctl_pkg::OP_HIT);
        misses_next = misses_reg + CW'(cmd.op == bctl_pkg::OP_MISS);
        moves_next  = moves_reg + CW'(cmd.op == bctl_pkg::OP_PROMOTE);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            capacity_reg <= bctl_pkg::CAPACITY_RESET;
            mr_reg       <= '0;
            least_reg    <= '0;
            used_reg     <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            moves_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bctl_pkg::REG_ENABLE:   enable_reg   <= cfg_data[0];
                    bctl_pkg::REG_CAPACITY: capacity_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (mr_we)
            begin
                mr_reg <= x_reg;
            end
            if (least_we)
            begin
                least_reg <= least_data;
            end
            if (used_inc)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.load)
            begin
                hits_reg   <= hits_next;
                misses_reg <= misses_next;
                moves_reg  <= moves_next;
            end
        end
    end

    // item, match and lookup registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            key_reg  <= sector;
        end
        if (cmd.step == bctl_pkg::S_MATCH)
        begin
            match_reg <= match_next;
        end
        if (cmd.step == bctl_pkg::S_LOOK)
        begin
            x_reg        <= x_next;
            nonempty_reg <= (used_reg != '0);
        end
    end

    // tag store and link memories
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            cam_reg[x_reg] <= key_reg;
            key_mem[x_reg] <= key_reg;
        end
        if (nw_we)
        begin
            newer_mem[nw_addr] <= nw_data;
        end
        if (ol_we)
        begin
            older_mem[ol_addr] <= ol_data;
        end
        if (cmd.step == bctl_pkg::S_LOOK)
        begin
            rd_key_reg   <= key_mem[x_next];
            rd_newer_reg <= newer_mem[x_next];
            rd_older_reg <= older_mem[x_next];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hit_reg        <= (cmd.op == bctl_pkg::OP_HIT) || (cmd.op == bctl_pkg::OP_HEAD) ||
                              (cmd.op == bctl_pkg::OP_PROMOTE);
            slot_reg       <= ((cmd.op == bctl_pkg::OP_OFF) || (cmd.op == bctl_pkg::OP_MISS)) ?
                              SLOT_W'(0) : x_reg;
            alloc_reg      <= (cmd.op == bctl_pkg::OP_ALLOC) || (cmd.op == bctl_pkg::OP_EVICT);
            evict_reg      <= (cmd.op == bctl_pkg::OP_EVICT);
            ev_key_reg     <= (cmd.op == bctl_pkg::OP_EVICT) ? rd_key_reg : KEY_WIDTH'(0);
            hit_count_reg  <= hits_next;
            miss_count_reg <= misses_next;
            move_count_reg <= moves_next;
        end
    end

    assign hit            = hit_reg;
    assign slot           = slot_reg;
    assign allocated      = alloc_reg;
    assign evicted        = evict_reg;
    assign evicted_sector = ev_key_reg;
    assign hit_count      = hit_count_reg;
    assign miss_count     = miss_count_reg;
    assign move_count     = move_count_reg;

    `BCTL_ASSERT_IMP(a_match_unique, cmd.step == bctl_pkg::S_LOOK, $onehot0(match_reg))
    `BCTL_ASSERT_NXT(a_used_inc, cmd.step == bctl_pkg::S_W1 && cmd.op == bctl_pkg::OP_ALLOC, used_reg == $past(used_reg) + 1'b1)
    `BCTL_ASSERT_NXT(a_head_set, cmd.step == bctl_pkg::S_W3, mr_reg == $past(x_reg))

endmodule
